FILE: hw/rtl/cfpl_pkg.sv
// Package for the command frame parser and latency tracker.
// Holds the shared types, codes and constants; no dependencies.
`timescale 1ns / 1ps

package cfpl_pkg;

  localparam int unsigned CmdW        = 6;
  localparam int unsigned LenW        = 16;
  localparam int unsigned LatW        = 14;
  localparam int unsigned RttW        = 13;
  localparam int unsigned CfgIdxW     = 2;

  localparam logic [LenW-1:0]   PING_LEN     = 16'd16;
  localparam logic [7:0]        PING_SUBTYPE = 8'd2;
  localparam logic [31:0]       LATENCY_LIM  = 32'd5000;
  localparam logic [LatW-1:0]   LAT_UNKNOWN  = 14'h3FFF;
  // Division by ten is done as a multiply by ceil(2^19 / 10) and a shift by 19.
  localparam logic [15:0]       DECAY_RECIP  = 16'd52429;
  localparam int unsigned       DECAY_SHIFT  = 19;

  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_SHORT = 2'd1;
  localparam logic [1:0] KIND_LONG  = 2'd2;

  localparam logic [13:0] STAMP_START_OFS = 14'd1;
  localparam logic [13:0] STAMP_END_OFS   = 14'd3;

  typedef enum logic [2:0] {
    PH_HEADER    = 3'd0,
    PH_SHORT_LEN = 3'd1,
    PH_LEN_LO    = 3'd2,
    PH_LEN_HI    = 3'd3,
    PH_PAYLOAD   = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    EV_NONE       = 2'd0,
    EV_LOGIN      = 2'd1,
    EV_DISCONNECT = 2'd2
  } event_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_LOGIN = 2'd0,
    REG_PING  = 2'd1,
    REG_DISC  = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [CmdW-1:0] login_code;
    logic [CmdW-1:0] ping_code;
    logic [CmdW-1:0] disconnect_code;
  } cfg_t;

  typedef struct packed {
    logic [CmdW-1:0] command;
    logic [7:0]      payload_byte;
    logic            payload_valid;
    logic [LenW-1:0] payload_offset;
    logic            frame_done;
    logic            bad_length_kind;
    event_e          session_event;
    logic [7:0]      permission_bits;
    logic            ping_meas;
    logic [RttW-1:0] rtt;
  } stage_t;

endpackage

FILE: hw/rtl/cfpl_ifs.sv
// Channel interfaces of the command frame parser: input bytes, configuration
// writes and results. Depends on cfpl_pkg.
`timescale 1ns / 1ps

interface cfpl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, rx_byte, input ready);
  modport sink (input valid, rx_byte, output ready);
endinterface

interface cfpl_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [cfpl_pkg::CfgIdxW-1:0] index;
  logic [cfpl_pkg::CmdW-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

interface cfpl_out_if;
  logic                            valid;
  logic                            ready;
  logic [cfpl_pkg::CmdW-1:0]       command;
  logic [7:0]                      payload_byte;
  logic                            payload_valid;
  logic [cfpl_pkg::LenW-1:0]       payload_offset;
  logic                            frame_done;
  logic                            bad_length_kind;
  logic [1:0]                      session_event;
  logic [7:0]                      permission_bits;
  logic signed [cfpl_pkg::LatW-1:0] latency_ms;
  logic                            latency_updated;
  modport source (output valid, command, payload_byte, payload_valid, payload_offset,
                  frame_done, bad_length_kind, session_event, permission_bits,
                  latency_ms, latency_updated, input ready);
  modport sink (input valid, command, payload_byte, payload_valid, payload_offset,
                frame_done, bad_length_kind, session_event, permission_bits,
                latency_ms, latency_updated, output ready);
endinterface

FILE: hw/rtl/cfpl_cfg_regs.sv
// Configuration registers holding the login, ping and disconnect command codes.
// Depends on cfpl_pkg.
`timescale 1ns / 1ps

module cfpl_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wr_valid_i,
  input  logic [cfpl_pkg::CfgIdxW-1:0]  wr_index_i,
  input  logic [cfpl_pkg::CmdW-1:0]     wr_data_i,
  output logic                          wr_ready_o,
  output cfpl_pkg::cfg_t                cfg_o
);

  cfpl_pkg::cfg_t cfg_q, cfg_d;

  assign wr_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_valid_i) begin
      unique case (wr_index_i)
        cfpl_pkg::REG_LOGIN: cfg_d.login_code      = wr_data_i;
        cfpl_pkg::REG_PING:  cfg_d.ping_code       = wr_data_i;
        cfpl_pkg::REG_DISC:  cfg_d.disconnect_code = wr_data_i;
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.login_code      <= 6'd1;
      cfg_q.ping_code       <= 6'd3;
      cfg_q.disconnect_code <= 6'd2;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: hw/rtl/cfpl_parser.sv
// Frame parser stage: walks header, length and payload bytes, captures the
// ping timestamps and permissions, and registers one stage record per byte.
// Depends on cfpl_pkg.
`timescale 1ns / 1ps

module cfpl_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cfpl_pkg::cfg_t       cfg_i,
  input  logic                 in_valid_i,
  input  logic [7:0]           in_byte_i,
  output logic                 in_ready_o,
  output cfpl_pkg::stage_t     stage_o,
  output logic                 stage_valid_o,
  input  logic                 stage_ready_i
);

  cfpl_pkg::phase_e              phase_q, phase_d;
  logic [cfpl_pkg::CmdW-1:0]     cmd_q, cmd_d;
  logic [cfpl_pkg::LenW-1:0]     len_q, len_d;
  logic [cfpl_pkg::LenW-1:0]     cnt_q, cnt_d, cnt_inc;
  logic [7:0]                    first_q, first_d;
  logic [3:0][7:0]               ss_q, ss_d;
  logic [3:0][7:0]               se_q, se_d;
  logic [7:0]                    perm_q, perm_d;
  logic [31:0]                   rtt;
  logic                          done;
  logic                          in_acc;
  cfpl_pkg::stage_t              st, stage_q;
  logic                          stage_valid_q;

  assign in_ready_o = !stage_valid_q || stage_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;
  assign cnt_inc    = cnt_q + 16'd1;
  assign rtt        = se_d - ss_d;

  always_comb begin
    phase_d  = phase_q;
    cmd_d    = cmd_q;
    len_d    = len_q;
    cnt_d    = cnt_q;
    first_d  = first_q;
    ss_d     = ss_q;
    se_d     = se_q;
    perm_d   = perm_q;
    done     = 1'b0;
    st       = '0;
    unique case (phase_q)
      cfpl_pkg::PH_SHORT_LEN: begin
        len_d = {8'd0, in_byte_i};
        if (in_byte_i == 8'd0) begin
          done    = 1'b1;
          phase_d = cfpl_pkg::PH_HEADER;
        end else begin
          phase_d = cfpl_pkg::PH_PAYLOAD;
        end
      end
      cfpl_pkg::PH_LEN_LO: begin
        len_d   = {8'd0, in_byte_i};
        phase_d = cfpl_pkg::PH_LEN_HI;
      end
      cfpl_pkg::PH_LEN_HI: begin
        len_d = {in_byte_i, len_q[7:0]};
        if (len_d == '0) begin
          done    = 1'b1;
          phase_d = cfpl_pkg::PH_HEADER;
        end else begin
          phase_d = cfpl_pkg::PH_PAYLOAD;
        end
      end
      cfpl_pkg::PH_PAYLOAD: begin
        st.payload_valid  = 1'b1;
        st.payload_byte   = in_byte_i;
        st.payload_offset = cnt_q;
        if (cnt_q == '0) begin
          first_d = in_byte_i;
        end
        if (cnt_q[15:2] == cfpl_pkg::STAMP_START_OFS) begin
          ss_d[cnt_q[1:0]] = in_byte_i;
        end
        if (cnt_q[15:2] == cfpl_pkg::STAMP_END_OFS) begin
          se_d[cnt_q[1:0]] = in_byte_i;
        end
        cnt_d = cnt_inc;
        if (cnt_inc >= len_q || cnt_inc == '0) begin
          done    = 1'b1;
          phase_d = cfpl_pkg::PH_HEADER;
        end
      end
      default: begin
        cmd_d   = in_byte_i[5:0];
        cnt_d   = '0;
        phase_d = cfpl_pkg::PH_HEADER;
        case (in_byte_i[7:6])
          cfpl_pkg::KIND_NONE: begin
            len_d = '0;
            done  = 1'b1;
          end
          cfpl_pkg::KIND_SHORT: phase_d = cfpl_pkg::PH_SHORT_LEN;
          cfpl_pkg::KIND_LONG:  phase_d = cfpl_pkg::PH_LEN_LO;
          default:              st.bad_length_kind = 1'b1;
        endcase
      end
    endcase

    if (done) begin
      if (cmd_d == cfg_i.login_code) begin
        if (len_d != '0) begin
          perm_d           = first_d;
          st.session_event = cfpl_pkg::EV_LOGIN;
        end
      end else if (cmd_d == cfg_i.ping_code) begin
        if (len_d == cfpl_pkg::PING_LEN && first_d == cfpl_pkg::PING_SUBTYPE &&
            !rtt[31] && rtt != '0 && rtt < cfpl_pkg::LATENCY_LIM) begin
          st.ping_meas = 1'b1;
        end
      end else if (cmd_d == cfg_i.disconnect_code) begin
        st.session_event = cfpl_pkg::EV_DISCONNECT;
      end
    end

    st.command         = cmd_d;
    st.frame_done      = done;
    st.permission_bits = perm_d;
    st.rtt             = rtt[cfpl_pkg::RttW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= cfpl_pkg::PH_HEADER;
      cmd_q         <= '0;
      len_q         <= '0;
      cnt_q         <= '0;
      first_q       <= '0;
      ss_q          <= '0;
      se_q          <= '0;
      perm_q        <= '0;
      stage_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        phase_q <= phase_d;
        cmd_q   <= cmd_d;
        len_q   <= len_d;
        cnt_q   <= cnt_d;
        first_q <= first_d;
        ss_q    <= ss_d;
        se_q    <= se_d;
        perm_q  <= perm_d;
      end
      if (in_ready_o) begin
        stage_valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      stage_q <= st;
    end
  end

  assign stage_o       = stage_q;
  assign stage_valid_o = stage_valid_q;

`ifndef SYNTHESIS
  a_payload_phase_gives_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && phase_q == cfpl_pkg::PH_PAYLOAD |=> stage_valid_q && stage_q.payload_valid)
    else $error("payload byte not marked valid");
  a_bad_kind_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_valid_q && stage_q.bad_length_kind |-> !stage_q.frame_done && !stage_q.payload_valid)
    else $error("reserved length kind completed a frame or carried payload");
`endif

endmodule

FILE: hw/rtl/cfpl_latency.sv
// Latency stage: applies the peak-hold latency update for measured pings and
// holds the result register. Depends on cfpl_pkg.
`timescale 1ns / 1ps

module cfpl_latency (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  cfpl_pkg::stage_t                  stage_i,
  input  logic                              stage_valid_i,
  output logic                              stage_ready_o,
  output logic                              res_valid_o,
  input  logic                              res_ready_i,
  output cfpl_pkg::stage_t                  res_o,
  output logic signed [cfpl_pkg::LatW-1:0]  res_latency_o
);

  logic signed [cfpl_pkg::LatW-1:0] lat_q, lat_d;
  logic signed [cfpl_pkg::LatW-1:0] diff;
  logic [28:0]                      prod;
  logic [cfpl_pkg::LatW-1:0]        decay;
  logic                             take_new;
  logic                             take;
  logic                             res_valid_q;
  cfpl_pkg::stage_t                 res_q;

  assign take          = !res_valid_q || res_ready_i;
  assign stage_ready_o = take;

  assign diff     = lat_q - $signed({1'b0, stage_i.rtt});
  assign take_new = lat_q[cfpl_pkg::LatW-1] || diff[cfpl_pkg::LatW-1] || diff == '0;
  assign prod     = diff[cfpl_pkg::RttW-1:0] * cfpl_pkg::DECAY_RECIP;
  assign decay    = {4'd0, prod[28:cfpl_pkg::DECAY_SHIFT]};

  always_comb begin
    lat_d = lat_q;
    if (stage_i.ping_meas) begin
      if (take_new) begin
        lat_d = $signed({1'b0, stage_i.rtt});
      end else begin
        lat_d = lat_q - $signed(decay);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lat_q       <= cfpl_pkg::LAT_UNKNOWN;
      res_valid_q <= 1'b0;
    end else if (take) begin
      res_valid_q <= stage_valid_i;
      if (stage_valid_i) begin
        lat_q <= lat_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && stage_valid_i) begin
      res_q <= stage_i;
    end
  end

  assign res_valid_o   = res_valid_q;
  assign res_o         = res_q;
  assign res_latency_o = lat_q;

`ifndef SYNTHESIS
  a_update_on_frame_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.ping_meas |-> res_q.frame_done)
    else $error("latency updated outside a frame end");
  a_latency_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lat_q == cfpl_pkg::LAT_UNKNOWN || (lat_q >= 14'sd1 && lat_q < 14'sd5000))
    else $error("held latency out of range");
`endif

endmodule

FILE: hw/rtl/command_frame_parser_latency_tracker.sv
// Top level of the command frame parser with round-trip latency tracker.
// Depends on cfpl_pkg, the cfpl interfaces, cfpl_cfg_regs, cfpl_parser and
// cfpl_latency.
//
// Usage: received link bytes enter on rx_if, one byte per transaction. Each
// byte yields exactly one result transaction on res_if with the current
// command, payload byte and offset, frame end and session flags, the latched
// permissions and the held latency. cfg_if writes the login, ping and
// disconnect command codes (index 0, 1, 2); it is always ready and should be
// used only while no bytes are in flight.
// An accepted byte's result passes through the parser register and then the
// latency/result register before it is valid on res_if.
// Throughput is one byte per cycle while res_if is ready; the parser state
// update is combinational; the latency update uses one 13x16 multiplier.
// Reset clears the parser to wait for a header, restores the default command
// codes, clears the permissions and sets the latency to -1 (not measured).
// When the receiver stalls, the result register holds its transaction; one
// more byte is taken only if the parser register is empty, and rx_if ready
// drops as soon as the parser register holds a waiting transaction.
`timescale 1ns / 1ps

module command_frame_parser_latency_tracker (
  input  logic        clk_i,
  input  logic        rst_ni,
  cfpl_in_if.sink     rx_if,
  cfpl_cfg_if.sink    cfg_if,
  cfpl_out_if.source  res_if
);

  cfpl_pkg::cfg_t   cfg;
  cfpl_pkg::stage_t stage;
  logic             stage_valid;
  logic             stage_ready;
  cfpl_pkg::stage_t res;

  cfpl_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (cfg_if.valid),
    .wr_index_i (cfg_if.index),
    .wr_data_i  (cfg_if.data),
    .wr_ready_o (cfg_if.ready),
    .cfg_o      (cfg)
  );

  cfpl_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .in_valid_i    (rx_if.valid),
    .in_byte_i     (rx_if.rx_byte),
    .in_ready_o    (rx_if.ready),
    .stage_o       (stage),
    .stage_valid_o (stage_valid),
    .stage_ready_i (stage_ready)
  );

  cfpl_latency u_latency (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .stage_i       (stage),
    .stage_valid_i (stage_valid),
    .stage_ready_o (stage_ready),
    .res_valid_o   (res_if.valid),
    .res_ready_i   (res_if.ready),
    .res_o         (res),
    .res_latency_o (res_if.latency_ms)
  );

  assign res_if.command         = res.command;
  assign res_if.payload_byte    = res.payload_byte;
  assign res_if.payload_valid   = res.payload_valid;
  assign res_if.payload_offset  = res.payload_offset;
  assign res_if.frame_done      = res.frame_done;
  assign res_if.bad_length_kind = res.bad_length_kind;
  assign res_if.session_event   = res.session_event;
  assign res_if.permission_bits = res.permission_bits;
  assign res_if.latency_updated = res.ping_meas;

endmodule

FILE: verif/tb_command_frame_parser_latency_tracker.sv
// Testbench for command_frame_parser_latency_tracker: feeds framed command byte streams,
// predicts every result transaction and compares it field by field.
// Depends on cfpl_pkg, the cfpl channel interfaces and the block under test.
`timescale 1ns / 1ps

module tb_command_frame_parser_latency_tracker;
  import cfpl_pkg::*;

  localparam int unsigned   CycleLimit    = 200_000;
  localparam int            RttLimit      = 5000;
  localparam int            DecayDivisor  = 10;
  localparam int unsigned   FramePingLen  = 16;
  localparam logic [7:0]    PingStampType = 8'd2;
  localparam logic [1:0]    KindReserved  = 2'd3;

  typedef logic [7:0] octets_t[$];

  typedef struct packed {
    logic [CmdW-1:0] command;
    logic [7:0]      payload_byte;
    logic            payload_valid;
    logic [LenW-1:0] payload_offset;
    logic            frame_done;
    logic            bad_length_kind;
    event_e          session_event;
    logic [7:0]      permission_bits;
    logic [LatW-1:0] latency_ms;
    logic            latency_updated;
  } parse_report_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  cfpl_in_if  rx_if ();
  cfpl_cfg_if cfg_if ();
  cfpl_out_if res_if ();

  command_frame_parser_latency_tracker DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_if  (rx_if),
    .cfg_if (cfg_if),
    .res_if (res_if)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Command codes as last written.
  logic [CmdW-1:0] code_login = 6'd1;
  logic [CmdW-1:0] code_ping  = 6'd3;
  logic [CmdW-1:0] code_disc  = 6'd2;

  // Parser and tracker state of the prediction.
  phase_e          rx_phase     = PH_HEADER;
  logic [CmdW-1:0] cur_cmd      = '0;
  logic [LenW-1:0] cur_len      = '0;
  logic [LenW-1:0] cur_count    = '0;
  logic [7:0]      first_byte   = '0;
  logic [31:0]     stamp_t0     = '0;
  logic [31:0]     stamp_t2     = '0;
  logic [7:0]      held_perm    = '0;
  logic [LatW-1:0] held_latency = '1;

  parse_report_t parse_reports_q[$];
  parse_report_t want;
  logic [7:0]    tx_bytes[$];
  octets_t       no_head;

  // Framing as seen by the generator, used to put the stream back on a header.
  phase_e          gen_phase = PH_HEADER;
  logic [LenW-1:0] gen_len   = '0;
  int              gen_count = 0;

  int queued = 0;
  int mismatches = 0;
  int frames_done = 0;
  int latency_updates = 0;
  int session_events = 0;
  int bad_headers = 0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_pct = 0;
  int stall_left = 0;
  int unsigned cycle_count = 0;

  function automatic parse_report_t parse_rx_byte(logic [7:0] b);
    parse_report_t r;
    logic          done;
    int            rtt;
    int            held;
    r = '0;
    done = 1'b0;
    case (rx_phase)
      PH_SHORT_LEN: begin
        cur_len = {8'h00, b};
        done = (cur_len == '0);
        rx_phase = done ? PH_HEADER : PH_PAYLOAD;
      end
      PH_LEN_LO: begin
        cur_len = {8'h00, b};
        rx_phase = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        cur_len = {b, cur_len[7:0]};
        done = (cur_len == '0);
        rx_phase = done ? PH_HEADER : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        r.payload_valid = 1'b1;
        r.payload_byte = b;
        r.payload_offset = cur_count;
        if (cur_count == '0) first_byte = b;
        if (cur_count >= 4 && cur_count <= 7) stamp_t0[8*(cur_count-4) +: 8] = b;
        if (cur_count >= 12 && cur_count <= 15) stamp_t2[8*(cur_count-12) +: 8] = b;
        cur_count = cur_count + 16'd1;
        if (cur_count >= cur_len || cur_count == '0) begin
          done = 1'b1;
          rx_phase = PH_HEADER;
        end
      end
      default: begin
        cur_cmd = b[5:0];
        cur_count = '0;
        rx_phase = PH_HEADER;
        case (b[7:6])
          KIND_NONE: begin
            cur_len = '0;
            done = 1'b1;
          end
          KIND_SHORT: rx_phase = PH_SHORT_LEN;
          KIND_LONG:  rx_phase = PH_LEN_LO;
          default: begin
            r.bad_length_kind = 1'b1;
            bad_headers++;
          end
        endcase
      end
    endcase

    if (done) begin
      frames_done++;
      if (cur_cmd == code_login) begin
        if (cur_len >= 1) begin
          held_perm = first_byte;
          r.session_event = EV_LOGIN;
        end
      end else if (cur_cmd == code_ping) begin
        if (cur_len == FramePingLen && first_byte == PingStampType) begin
          rtt = $signed(stamp_t2 - stamp_t0);
          if (rtt > 0 && rtt < RttLimit) begin
            held = $signed(held_latency);
            if (held < 0 || rtt >= held) held = rtt;
            else held = held - (held - rtt) / DecayDivisor;
            held_latency = held[LatW-1:0];
            r.latency_updated = 1'b1;
            latency_updates++;
          end
        end
      end else if (cur_cmd == code_disc) begin
        r.session_event = EV_DISCONNECT;
      end
      if (r.session_event != EV_NONE) session_events++;
    end

    r.command = cur_cmd;
    r.frame_done = done;
    r.permission_bits = held_perm;
    r.latency_ms = held_latency;
    return r;
  endfunction

  function automatic void check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (act_v !== exp_v) begin
      mismatches++;
      if (mismatches <= 100) $error("%s: expected %0h, got %0h", name, exp_v, act_v);
    end
  endfunction

  task automatic queue_byte(logic [7:0] b);
    tx_bytes.push_back(b);
    queued++;
    case (gen_phase)
      PH_SHORT_LEN: begin
        gen_len = {8'h00, b};
        gen_count = 0;
        gen_phase = (gen_len == '0) ? PH_HEADER : PH_PAYLOAD;
      end
      PH_LEN_LO: begin
        gen_len = {8'h00, b};
        gen_phase = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        gen_len = {b, gen_len[7:0]};
        gen_count = 0;
        gen_phase = (gen_len == '0) ? PH_HEADER : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        gen_count++;
        if (gen_count >= gen_len) gen_phase = PH_HEADER;
      end
      default: begin
        case (b[7:6])
          KIND_SHORT: gen_phase = PH_SHORT_LEN;
          KIND_LONG:  gen_phase = PH_LEN_LO;
          default:    gen_phase = PH_HEADER;
        endcase
      end
    endcase
  endtask

  // Random byte that never announces a length above 24.
  function automatic logic [7:0] filler();
    case (gen_phase)
      PH_SHORT_LEN, PH_LEN_LO: return 8'($urandom_range(0, 24));
      PH_LEN_HI:               return 8'h00;
      default:                 return 8'($urandom);
    endcase
  endfunction

  task automatic realign();
    while (gen_phase != PH_HEADER) queue_byte(filler());
  endtask

  task automatic queue_frame(logic [CmdW-1:0] cmd, logic [1:0] kind, logic [LenW-1:0] len,
                             octets_t head);
    queue_byte({kind, cmd});
    if (kind == KIND_SHORT) queue_byte(len[7:0]);
    if (kind == KIND_LONG) begin
      queue_byte(len[7:0]);
      queue_byte(len[15:8]);
    end
    if (kind == KIND_SHORT || kind == KIND_LONG) begin
      for (int i = 0; i < int'(len); i++) begin
        queue_byte((i < head.size()) ? head[i] : 8'($urandom));
      end
    end
  endtask

  function automatic octets_t ping_body(logic [7:0] ptype, logic [31:0] t0, logic [31:0] rtt);
    octets_t     q;
    logic [31:0] t2;
    t2 = t0 + rtt;
    for (int i = 0; i < FramePingLen; i++) q.push_back(8'($urandom));
    q[0] = ptype;
    for (int i = 0; i < 4; i++) begin
      q[4+i] = t0[8*i +: 8];
      q[12+i] = t2[8*i +: 8];
    end
    return q;
  endfunction

  function automatic logic [31:0] pick_rtt();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return $urandom_range(1, RttLimit - 1);
      5: return $urandom_range(1, 60);
      6: begin
        case ($urandom_range(0, 3))
          0: return 32'd0;
          1: return 32'd1;
          2: return RttLimit - 1;
          default: return RttLimit;
        endcase
      end
      7: return -$urandom_range(1, RttLimit);
      8: return $urandom_range(RttLimit + 1, 100000);
      default: return $urandom;
    endcase
  endfunction

  task automatic random_traffic(int target);
    int              start;
    int              sel;
    int              len;
    logic [1:0]      kind;
    logic [7:0]      ptype;
    start = queued;
    while (queued - start < target) begin
      realign();
      sel = $urandom_range(0, 99);
      case ($urandom_range(0, 2))
        0: kind = KIND_NONE;
        1: kind = KIND_SHORT;
        default: kind = KIND_LONG;
      endcase
      if (sel < 30) begin
        len = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 20) : FramePingLen;
        if (kind == KIND_NONE) kind = KIND_SHORT;
        ptype = ($urandom_range(0, 6) == 0) ? 8'($urandom) : PingStampType;
        queue_frame(code_ping, kind, LenW'(len), ping_body(ptype, $urandom, pick_rtt()));
      end else if (sel < 45) begin
        len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
        queue_frame(code_login, kind, LenW'(len), no_head);
      end else if (sel < 55) begin
        queue_frame(code_disc, kind, LenW'($urandom_range(0, 6)), no_head);
      end else if (sel < 84) begin
        len = ($urandom_range(0, 24) == 0) ? $urandom_range(256, 300) : $urandom_range(0, 40);
        if (len > 255) kind = KIND_LONG;
        queue_frame(6'($urandom), kind, LenW'(len), no_head);
      end else if (sel < 94) begin
        queue_byte({KindReserved, 6'($urandom)});
      end else begin
        for (int i = $urandom_range(1, 6); i > 0; i--) queue_byte(filler());
      end
    end
    realign();
  endtask

  task automatic drain();
    while (tx_bytes.size() != 0 || rx_if.valid || parse_reports_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [CmdW-1:0] val);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      REG_LOGIN: code_login = val;
      REG_PING:  code_ping = val;
      default:   code_disc = val;
    endcase
  endtask

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rx_if.valid <= 1'b0;
      rx_if.rx_byte <= '0;
    end else begin
      if (rx_if.valid && rx_if.ready) parse_reports_q.push_back(parse_rx_byte(rx_if.rx_byte));
      if (!(rx_if.valid && !rx_if.ready)) begin
        if (gap_left > 0 || tx_bytes.size() == 0) begin
          rx_if.valid <= 1'b0;
          if (gap_left > 0) gap_left--;
        end else begin
          rx_if.valid <= 1'b1;
          rx_if.rx_byte <= tx_bytes.pop_front();
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (parse_reports_q.size() == 0) begin
          mismatches++;
          $error("result transaction with no byte outstanding");
        end else begin
          want = parse_reports_q.pop_front();
          check_field("command", 16'(want.command), 16'(res_if.command));
          check_field("payload_byte", 16'(want.payload_byte), 16'(res_if.payload_byte));
          check_field("payload_valid", 16'(want.payload_valid), 16'(res_if.payload_valid));
          check_field("payload_offset", want.payload_offset, res_if.payload_offset);
          check_field("frame_done", 16'(want.frame_done), 16'(res_if.frame_done));
          check_field("bad_length_kind", 16'(want.bad_length_kind),
                      16'(res_if.bad_length_kind));
          check_field("session_event", 16'(want.session_event), 16'(res_if.session_event));
          check_field("permission_bits", 16'(want.permission_bits),
                      16'(res_if.permission_bits));
          check_field("latency_ms", 16'(want.latency_ms), 16'($unsigned(res_if.latency_ms)));
          check_field("latency_updated", 16'(want.latency_updated),
                      16'(res_if.latency_updated));
        end
      end
      if (stall_left == 0) begin
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 20;
          2: stall_pct = 50;
          default: stall_pct = 80;
        endcase
        stall_left = $urandom_range(16, 160);
      end else begin
        stall_left--;
      end
      res_if.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  initial begin
    octets_t         head;
    logic [CmdW-1:0] shared;
    rx_if.valid = 1'b0;
    rx_if.rx_byte = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_LOGIN;
    cfg_if.data = '0;
    res_if.ready = 1'b0;
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Edge cases under the default codes: empty and reserved headers, login with and
    // without payload, an empty two-byte length and a ping whose stamps wrap.
    queue_byte({KIND_NONE, 6'h00});
    queue_byte({KindReserved, 6'h3F});
    queue_frame(code_login, KIND_NONE, 16'd0, no_head);
    head.push_back(8'hA5);
    queue_frame(code_login, KIND_SHORT, 16'd1, head);
    queue_frame(code_disc, KIND_LONG, 16'd0, no_head);
    queue_frame(code_ping, KIND_SHORT, LenW'(FramePingLen),
                ping_body(PingStampType, 32'hFFFF_FFF0, 32'd100));
    random_traffic(120);
    drain();

    // Ping and disconnect share a code, so ping handling has to win.
    write_reg(REG_LOGIN, 6'd0);
    write_reg(REG_PING, 6'd63);
    write_reg(REG_DISC, 6'd63);
    random_traffic(120);
    drain();

    write_reg(REG_LOGIN, 6'd63);
    write_reg(REG_PING, 6'd0);
    write_reg(REG_DISC, 6'd0);
    random_traffic(120);
    drain();

    // All three codes equal, so login handling has to win.
    shared = 6'($urandom);
    write_reg(REG_LOGIN, shared);
    write_reg(REG_PING, shared);
    write_reg(REG_DISC, shared);
    random_traffic(120);
    drain();

    write_reg(REG_LOGIN, 6'($urandom));
    write_reg(REG_PING, 6'($urandom));
    write_reg(REG_DISC, 6'($urandom));
    random_traffic(120);
    drain();

    if (parse_reports_q.size() != 0) begin
      mismatches++;
      $error("%0d result transactions never arrived", parse_reports_q.size());
    end
    $display("Sent %0d bytes over five code settings, with occasional long two-byte frames.",
             queued);
    $display("Frames closed: %0d, latency updates: %0d, session events: %0d, bad headers: %0d.",
             frames_done, latency_updates, session_events, bad_headers);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
